[design/sobel_gradient_3x3_defines.svh]
`ifndef SOBEL_GRADIENT_3X3_DEFINES_SVH
`define SOBEL_GRADIENT_3X3_DEFINES_SVH

// same-cycle implication on clk_i, off during reset
`define SG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication on clk_i, off during reset
`define SG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[design/sg_pkg.sv]
`default_nettype none

package sg_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int COL_W     = 11;
  localparam int ROW_W     = 12;
  localparam int CFG_W     = 12;
  localparam int PIX_W     = 24;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd480;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_DIRECTION    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [7:0] red;
    logic signed [7:0] green;
    logic signed [7:0] blue;
  } grad_t;

  // mask bit 0: centre (col-1,row-1), bit 1: row end (col,row-1), bit 2: last row (col,row)
  typedef struct packed {
    logic [2:0]       mask;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    grad_t            grad;
  } emit_req_t;

endpackage

`default_nettype wire

[design/sg_line_ram.sv]
`default_nettype none

module sg_line_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 24
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[design/sg_window.sv]
`default_nettype none

module sg_window import sg_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             shift_i,
  input  wire logic             direction_i,
  input  wire logic [PIX_W-1:0] up_i,
  input  wire logic [PIX_W-1:0] lo_i,
  input  wire logic [PIX_W-1:0] px_i,
  output grad_t                 grad_o
);

  logic [PIX_W-1:0] win_q [9];
  logic [PIX_W-1:0] win_d [9];

  function automatic logic [9:0] tri_sum(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
  endfunction

  // (pos - neg) / 8, truncating toward zero
  function automatic logic signed [7:0] div8(logic [9:0] pos, logic [9:0] neg);
    logic signed [10:0] d;
    logic signed [10:0] b;
    d = $signed({1'b0, pos}) - $signed({1'b0, neg});
    b = d + (d[10] ? 11'sd7 : 11'sd0);
    return b[10:3];
  endfunction

  function automatic logic signed [7:0] chan_grad(logic dir, int sh,
                                                  logic [PIX_W-1:0] w0, logic [PIX_W-1:0] w1,
                                                  logic [PIX_W-1:0] w2, logic [PIX_W-1:0] w3,
                                                  logic [PIX_W-1:0] w5, logic [PIX_W-1:0] w6,
                                                  logic [PIX_W-1:0] w7, logic [PIX_W-1:0] w8);
    logic [9:0] p;
    logic [9:0] n;
    if (dir) begin
      p = tri_sum(w0[sh +: 8], w1[sh +: 8], w2[sh +: 8]);
      n = tri_sum(w6[sh +: 8], w7[sh +: 8], w8[sh +: 8]);
    end else begin
      p = tri_sum(w2[sh +: 8], w5[sh +: 8], w8[sh +: 8]);
      n = tri_sum(w0[sh +: 8], w3[sh +: 8], w6[sh +: 8]);
    end
    return div8(p, n);
  endfunction

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]     = win_q[r*3+1];
      win_d[r*3 + 1] = win_q[r*3+2];
    end
    win_d[2] = up_i;
    win_d[5] = lo_i;
    win_d[8] = px_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (shift_i) begin
      win_q <= win_d;
    end
  end

  always_comb begin
    grad_o.red   = chan_grad(direction_i, 16, win_d[0], win_d[1], win_d[2], win_d[3],
                             win_d[5], win_d[6], win_d[7], win_d[8]);
    grad_o.green = chan_grad(direction_i, 8, win_d[0], win_d[1], win_d[2], win_d[3],
                             win_d[5], win_d[6], win_d[7], win_d[8]);
    grad_o.blue  = chan_grad(direction_i, 0, win_d[0], win_d[1], win_d[2], win_d[3],
                             win_d[5], win_d[6], win_d[7], win_d[8]);
  end

endmodule

`default_nettype wire

[design/sg_emit.sv]
`default_nettype none

module sg_emit import sg_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       req_valid_i,
  input  wire emit_req_t  req_i,
  output logic            req_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [COL_W-1:0] col_o,
  output logic [ROW_W-1:0] row_o,
  output grad_t           grad_o,
  output logic            last_o
);

  logic [2:0] mask_q, mask_d, mask_rest;
  emit_req_t  rec_q;
  logic       out_xfer;

  assign mask_rest   = mask_q & (mask_q - 3'd1);
  assign out_valid_o = |mask_q;
  assign out_xfer    = out_valid_o && out_ready_i;
  assign last_o      = (mask_rest == 3'd0);
  assign req_ready_o = out_xfer ? last_o : !out_valid_o;

  always_comb begin
    mask_d = out_xfer ? mask_rest : mask_q;
    if (req_valid_i && req_ready_o) begin
      mask_d = req_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      rec_q <= req_i;
    end
  end

  always_comb begin
    col_o  = rec_q.col;
    row_o  = rec_q.row;
    grad_o = '0;
    if (mask_q[0]) begin
      col_o  = rec_q.col - 11'd1;
      row_o  = rec_q.row - 12'd1;
      grad_o = rec_q.grad;
    end else if (mask_q[1]) begin
      row_o  = rec_q.row - 12'd1;
    end
  end

endmodule

`default_nettype wire

[design/sobel_gradient_3x3.sv]
// Pipeline: a pixel is registered in s1, then its request in the emit block's mask register.
// Throughput: one pixel per cycle while each pixel gives at most one result and out_ready_i
//   is high; a pixel giving k results (row end, last row) holds the input until the
//   single output port has drained them, one per cycle while out_ready_i is high.
// Reset: size 640x480, horizontal kernel, position 0,0, window zero; line memories
//   are not cleared.
`default_nettype none

`include "sobel_gradient_3x3_defines.svh"

module sobel_gradient_3x3 import sg_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       red_in_i,
  input  wire logic [7:0]       green_in_i,
  input  wire logic [7:0]       blue_in_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [COL_W-1:0]      col_o,
  output logic [ROW_W-1:0]      row_o,
  output logic signed [7:0]     red_grad_o,
  output logic signed [7:0]     green_grad_o,
  output logic signed [7:0]     blue_grad_o,
  output logic                  last_of_run_o
);

  logic [CFG_W-1:0] frame_width_q, frame_height_q;
  logic             direction_q;

  logic [COL_W-1:0] col_q, col_d, wlast, x0;
  logic [ROW_W-1:0] row_q, row_d, hlast, y0;
  logic             in_xfer;

  logic             s1_valid_q;
  logic [COL_W-1:0] s1_col_q;
  logic [ROW_W-1:0] s1_row_q;
  logic [2:0]       s1_mask_q;
  logic             s1_center_q;
  logic [PIX_W-1:0] s1_px_q;
  logic             s1_fire;

  logic [PIX_W-1:0] up_rdata, lo_rdata;
  grad_t            win_grad, out_grad;
  emit_req_t        req;
  logic             req_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= RST_FRAME_WIDTH;
      frame_height_q <= RST_FRAME_HEIGHT;
      direction_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        CFG_DIRECTION:    direction_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width_q < 12'd3) begin
      wlast = 11'd2;
    end else if (frame_width_q > 12'(MAX_WIDTH)) begin
      wlast = 11'(MAX_WIDTH - 1);
    end else begin
      wlast = 11'(frame_width_q - 12'd1);
    end
    hlast = (frame_height_q < 12'd3) ? 12'd2 : frame_height_q - 12'd1;
    x0    = (col_q > wlast) ? wlast : col_q;
    y0    = (row_q > hlast) ? hlast : row_q;
  end

  assign s1_fire    = s1_valid_q && req_ready;
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    if (x0 == wlast) begin
      col_d = '0;
      row_d = (y0 == hlast) ? '0 : y0 + 12'd1;
    end else begin
      col_d = x0 + 11'd1;
      row_d = y0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_col_q    <= x0;
      s1_row_q    <= y0;
      s1_mask_q   <= {y0 == hlast, (x0 == wlast) && (y0 != '0), (x0 != '0) && (y0 != '0)};
      s1_center_q <= (x0 >= 11'd2) && (y0 >= 12'd2);
      s1_px_q     <= {red_in_i, green_in_i, blue_in_i};
    end
  end

  // upper row store takes the old lower row, lower row store takes the new pixel
  sg_line_ram #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_W)) u_ram_upper (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (lo_rdata),
    .re_i    (in_xfer),
    .raddr_i (x0),
    .rdata_o (up_rdata)
  );

  sg_line_ram #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_W)) u_ram_lower (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (s1_px_q),
    .re_i    (in_xfer),
    .raddr_i (x0),
    .rdata_o (lo_rdata)
  );

  sg_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_i     (s1_fire),
    .direction_i (direction_q),
    .up_i        (up_rdata),
    .lo_i        (lo_rdata),
    .px_i        (s1_px_q),
    .grad_o      (win_grad)
  );

  always_comb begin
    req.mask = s1_mask_q;
    req.col  = s1_col_q;
    req.row  = s1_row_q;
    req.grad = s1_center_q ? win_grad : '0;
  end

  sg_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s1_valid_q),
    .req_i       (req),
    .req_ready_o (req_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .col_o       (col_o),
    .row_o       (row_o),
    .grad_o      (out_grad),
    .last_o      (last_of_run_o)
  );

  assign red_grad_o   = out_grad.red;
  assign green_grad_o = out_grad.green;
  assign blue_grad_o  = out_grad.blue;

  `SG_ASSERT_NOW(a_no_rw_collision, in_xfer && s1_fire, x0 != s1_col_q, "line store read and write hit one column")
  `SG_ASSERT_NEXT(a_rdata_held, s1_valid_q && !s1_fire, $stable(up_rdata) && $stable(lo_rdata), "line store data lost while stalled")
  `SG_ASSERT_NEXT(a_col_in_range, in_xfer, col_q <= $past(wlast), "column counter beyond row end")

endmodule

`default_nettype wire
